[design/easing_interpolator_top_assert.svh]
// Assertion macros used by the easing interpolator top level.
`ifndef EASING_INTERPOLATOR_TOP_ASSERT_SVH
`define EASING_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EI_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("easing interpolator check failed");
`define EI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("easing interpolator check failed");
`else
`define EI_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define EI_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

[design/ei_pkg.sv]
// Package with the request and response types of the easing interpolator.
package ei_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int TIME_WIDTH  = 32;

    typedef enum logic [1:0] {
        EASE_LINEAR      = 2'd0,
        EASE_QUINT_IN    = 2'd1,
        EASE_QUINT_OUT   = 2'd2,
        EASE_QUAD_IN_OUT = 2'd3
    } ease_mode_t;

    typedef struct packed {
        ease_mode_t                     ease_mode;
        logic signed [VALUE_WIDTH-1:0]  start_value;
        logic signed [VALUE_WIDTH-1:0]  dest_value;
        logic [TIME_WIDTH-1:0]          start_time;
        logic [TIME_WIDTH-1:0]          end_time;
        logic [TIME_WIDTH-1:0]          now_time;
    } ei_req_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  current_value;
        logic                           finished;
    } ei_rsp_t;

endpackage

[design/ei_div.sv]
// Pipelined restoring divider giving a fraction of progress, one quotient bit per stage.
module ei_div #(
    parameter int PROGRESS_BITS = 16
) (
    input  logic                              clk,
    input  logic [PROGRESS_BITS-1:0]          en,
    input  logic [ei_pkg::TIME_WIDTH-1:0]     num,
    input  logic [ei_pkg::TIME_WIDTH-1:0]     den,
    output logic [PROGRESS_BITS-1:0]          quo
);

    localparam int TW = ei_pkg::TIME_WIDTH;
    localparam int PB = PROGRESS_BITS;

    logic [TW-1:0] rem_reg [PB];
    logic [TW-1:0] den_reg [PB];
    logic [PB-1:0] quo_reg [PB];
    logic [TW-1:0] rem_next [PB];
    logic [PB-1:0] quo_next [PB];

    always_comb
    begin
        logic [TW-1:0] rem_src;
        logic [TW-1:0] den_src;
        logic [PB-1:0] quo_src;
        logic [TW:0]   shifted;
        for (int i = 0; i < PB; i++)
        begin
            if (i == 0)
            begin
                rem_src = num;
                den_src = den;
                quo_src = '0;
            end
            else
            begin
                rem_src = rem_reg[i-1];
                den_src = den_reg[i-1];
                quo_src = quo_reg[i-1];
            end
            shifted = {rem_src, 1'b0};
            if (shifted >= {1'b0, den_src})
            begin
                rem_next[i] = TW'(shifted - {1'b0, den_src});
                quo_next[i] = {quo_src[PB-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = shifted[TW-1:0];
                quo_next[i] = {quo_src[PB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PB; i++)
        begin
            if (en[i])
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= (i == 0) ? den : den_reg[i-1];
            end
        end
    end

    assign quo = quo_reg[PB-1];

endmodule

[design/easing_interpolator_top.sv]
// Top level of the pipelined easing interpolator.
// It takes one request per cycle unless stalled and returns one response each, in order.
// A request passes through PROGRESS_BITS + 8 register stages: one input stage, one stage
// per progress bit in the divider, six stages that shape the curve and scale the change,
// and the output register. Each stage moves forward whenever the stage after it is empty
// or moving, so bubbles close up while the output is stalled and new requests keep
// entering.
module easing_interpolator_top #(
    parameter int PROGRESS_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ei_pkg::ei_req_t req,
    input  logic            req_valid,
    output logic            req_stall,
    output ei_pkg::ei_rsp_t rsp,
    output logic            rsp_valid,
    input  logic            rsp_stall
);

    localparam int VW = ei_pkg::VALUE_WIDTH;
    localparam int TW = ei_pkg::TIME_WIDTH;
    localparam int PB = PROGRESS_BITS;
    localparam int NS = PB + 8;
    localparam int S1 = PB + 1;
    localparam int S2 = PB + 2;
    localparam int S3 = PB + 3;
    localparam int S4 = PB + 4;
    localparam int S5 = PB + 5;
    localparam int S6 = PB + 6;
    localparam int SO = PB + 7;
    localparam logic [PB:0] ONE  = {1'b1, {PB{1'b0}}};
    localparam logic [PB:0] HALF = {2'b01, {(PB-1){1'b0}}};

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] rdy;

    ei_pkg::ease_mode_t      mode_reg [NS-1];
    logic signed [VW-1:0]    sv_reg   [NS-1];
    logic signed [VW-1:0]    dv_reg   [NS-1];
    logic                    done_reg [NS-1];
    logic                    neg_reg  [NS-1];
    logic [VW:0]             mag_reg  [NS-1];
    logic [TW-1:0]           num_reg;
    logic [TW-1:0]           den_reg;
    logic [PB-1:0]           quo;

    logic [PB-1:0]           p1_reg, p2_reg, p3_reg, p4_reg;
    logic                    low1_reg, low2_reg, low3_reg, low4_reg;
    logic [PB:0]             a1_reg, a2_reg, a3_reg;
    logic [2*PB+1:0]         sq2_reg, sq3_reg, sq4_reg;
    logic [2*PB+1:0]         prod3_reg, prod4_reg;
    logic [PB:0]             f_reg;
    logic [VW+1:0]           hiprod_reg;
    logic [2*PB:0]           loprod_reg;
    ei_pkg::ei_rsp_t         rsp_reg;

    logic                    in_done, in_before, in_neg;
    logic [TW-1:0]           in_num, in_den;
    logic signed [VW:0]      in_diff;
    logic [VW:0]             in_mag;
    logic                    p_low;
    logic [PB:0]             a_next;
    logic [PB:0]             f_next;
    logic [PB:0]             a4, a5;
    logic [VW-PB:0]          mag_hi;
    logic [PB-1:0]           mag_lo;
    logic [VW+1:0]           adj;
    logic signed [VW+1:0]    sv_ext, res_sum;
    ei_pkg::ei_rsp_t         rsp_next;

    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || !rsp_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign req_stall = !rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                begin
                    valid_reg[i] <= (i == 0) ? req_valid : valid_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        in_done   = (req.now_time >= req.end_time) || (req.end_time == req.start_time);
        in_before = req.now_time < req.start_time;
        in_num    = in_before ? '0 : TW'(req.now_time - req.start_time);
        in_den    = TW'(req.end_time - req.start_time);
        in_diff   = {req.dest_value[VW-1], req.dest_value}
                  - {req.start_value[VW-1], req.start_value};
        in_neg    = in_diff[VW];
        in_mag    = in_neg ? (VW+1)'(-in_diff) : in_diff;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS - 1; i++)
        begin
            if (rdy[i])
            begin
                if (i == 0)
                begin
                    mode_reg[i] <= req.ease_mode;
                    sv_reg[i]   <= req.start_value;
                    dv_reg[i]   <= req.dest_value;
                    done_reg[i] <= in_done;
                    neg_reg[i]  <= in_neg;
                    mag_reg[i]  <= in_mag;
                end
                else
                begin
                    mode_reg[i] <= mode_reg[i-1];
                    sv_reg[i]   <= sv_reg[i-1];
                    dv_reg[i]   <= dv_reg[i-1];
                    done_reg[i] <= done_reg[i-1];
                    neg_reg[i]  <= neg_reg[i-1];
                    mag_reg[i]  <= mag_reg[i-1];
                end
            end
        end
        if (rdy[0])
        begin
            num_reg <= in_num;
            den_reg <= in_den;
        end
    end

    ei_div #(
        .PROGRESS_BITS(PB)
    ) u_div (
        .clk (clk),
        .en  (rdy[PB:1]),
        .num (num_reg),
        .den (den_reg),
        .quo (quo)
    );

    always_comb
    begin
        p_low = {1'b0, quo} < HALF;
        unique case (mode_reg[PB])
            ei_pkg::EASE_LINEAR:      a_next = {1'b0, quo};
            ei_pkg::EASE_QUINT_IN:    a_next = {1'b0, quo};
            ei_pkg::EASE_QUINT_OUT:   a_next = ONE - {1'b0, quo};
            ei_pkg::EASE_QUAD_IN_OUT: a_next = p_low ? {1'b0, quo}
                                                     : (PB+1)'((ONE - {1'b0, quo}) << 1);
            default:                  a_next = {1'b0, quo};
        endcase
    end

    always_comb
    begin
        a4 = prod3_reg[2*PB:PB];
        a5 = prod4_reg[2*PB:PB];
        unique case (mode_reg[S4])
            ei_pkg::EASE_LINEAR:      f_next = {1'b0, p4_reg};
            ei_pkg::EASE_QUINT_IN:    f_next = a5;
            ei_pkg::EASE_QUINT_OUT:   f_next = ONE - a5;
            ei_pkg::EASE_QUAD_IN_OUT: f_next = low4_reg ? (PB+1)'(sq4_reg[2*PB+1:PB-1])
                                                        : ONE - sq4_reg[2*PB+1:PB+1];
            default:                  f_next = {1'b0, p4_reg};
        endcase
    end

    assign mag_hi = mag_reg[S5][VW:PB];
    assign mag_lo = mag_reg[S5][PB-1:0];

    always_comb
    begin
        adj     = hiprod_reg + (VW+2)'(loprod_reg[2*PB:PB]);
        sv_ext  = {{2{sv_reg[S6][VW-1]}}, sv_reg[S6]};
        res_sum = neg_reg[S6] ? sv_ext - signed'(adj) : sv_ext + signed'(adj);
        if (done_reg[S6])
        begin
            rsp_next.current_value = dv_reg[S6];
            rsp_next.finished      = 1'b1;
        end
        else
        begin
            rsp_next.current_value = res_sum[VW-1:0];
            rsp_next.finished      = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S1])
        begin
            p1_reg   <= quo;
            low1_reg <= p_low;
            a1_reg   <= a_next;
        end
        if (rdy[S2])
        begin
            p2_reg   <= p1_reg;
            low2_reg <= low1_reg;
            a2_reg   <= a1_reg;
            sq2_reg  <= a1_reg * a1_reg;
        end
        if (rdy[S3])
        begin
            p3_reg    <= p2_reg;
            low3_reg  <= low2_reg;
            a3_reg    <= a2_reg;
            sq3_reg   <= sq2_reg;
            prod3_reg <= sq2_reg[2*PB:PB] * sq2_reg[2*PB:PB];
        end
        if (rdy[S4])
        begin
            p4_reg    <= p3_reg;
            low4_reg  <= low3_reg;
            sq4_reg   <= sq3_reg;
            prod4_reg <= a4 * a3_reg;
        end
        if (rdy[S5])
        begin
            f_reg <= f_next;
        end
        if (rdy[S6])
        begin
            hiprod_reg <= mag_hi * f_reg;
            loprod_reg <= mag_lo * f_reg;
        end
        if (rdy[SO])
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = valid_reg[SO];

`include "easing_interpolator_top_assert.svh"

    `EI_ASSERT_IMPLY(a_stall_only_when_full, clk, rst_n, req_stall, &valid_reg)
    `EI_ASSERT_NEXT(a_request_enters, clk, rst_n, req_valid && !req_stall, valid_reg[0])
    `EI_ASSERT_IMPLY(a_factor_in_range, clk, rst_n, valid_reg[S5], f_reg <= ONE)
    `EI_ASSERT_IMPLY(a_linear_factor, clk, rst_n, valid_reg[S4] && rdy[S5] && mode_reg[S4] == ei_pkg::EASE_LINEAR, f_next[PB-1:0] == p4_reg && !f_next[PB])

endmodule

[tb/sv/tb_easing_interpolator_top.sv]
// Testbench for the easing interpolator: random and directed tweens checked against a predictor.
`timescale 1ns / 100ps

module tb_easing_interpolator_top;

    localparam int PBITS = 16;
    localparam longint unsigned ONE = 64'd1 << PBITS;
    localparam int LATENCY = PBITS + 8;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    ei_pkg::ei_req_t req = '0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    ei_pkg::ei_rsp_t rsp;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;

    ei_pkg::ei_req_t pending_reqs[$];
    ei_pkg::ei_rsp_t expected_rsps[$];
    int      error_count = 0;
    bit      stim_done = 1'b0;
    bit      hold_off = 1'b0;

    easing_interpolator_top #(.PROGRESS_BITS(PBITS)) u_dut (
        .clk(clk), .rst_n(rst_n), .req(req), .req_valid(req_valid),
        .req_stall(req_stall), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
    );

    always #6 clk = ~clk;

    function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
        return (a * b) >> PBITS;
    endfunction

    function automatic longint unsigned fifth_power(longint unsigned a);
        longint unsigned a2;
        longint unsigned a4;
        a2 = fix_mul(a, a);
        a4 = fix_mul(a2, a2);
        return fix_mul(a4, a);
    endfunction

    function automatic ei_pkg::ei_rsp_t interpolate(ei_pkg::ei_req_t r);
        ei_pkg::ei_rsp_t o;
        longint unsigned span;
        longint unsigned rem;
        longint unsigned p;
        longint unsigned f;
        longint unsigned q;
        longint unsigned mag;
        longint unsigned adj;
        longint          sv;
        longint          dv;
        longint          diff;
        sv = longint'(r.start_value);
        dv = longint'(r.dest_value);
        if (r.now_time >= r.end_time || r.end_time == r.start_time)
        begin
            o.current_value = r.dest_value;
            o.finished = 1'b1;
            return o;
        end
        p = 0;
        if (r.now_time >= r.start_time)
        begin
            rem = longint'(r.now_time - r.start_time);
            span = longint'(r.end_time - r.start_time);
            for (int i = 0; i < PBITS; i++)
            begin
                rem = rem << 1;
                p = p << 1;
                if (rem >= span)
                begin
                    rem -= span;
                    p |= 1;
                end
            end
        end
        case (r.ease_mode)
            ei_pkg::EASE_LINEAR:    f = p;
            ei_pkg::EASE_QUINT_IN:  f = fifth_power(p);
            ei_pkg::EASE_QUINT_OUT: f = ONE - fifth_power(ONE - p);
            default:
            begin
                if (p < (ONE >> 1))
                    f = (p * p) >> (PBITS - 1);
                else
                begin
                    q = 2 * (ONE - p);
                    f = ONE - ((q * q) >> (PBITS + 1));
                end
            end
        endcase
        diff = dv - sv;
        mag = diff < 0 ? longint'(-diff) : longint'(diff);
        adj = (mag >> PBITS) * f + (((mag & (ONE - 1)) * f) >> PBITS);
        o.current_value = 32'(diff < 0 ? sv - longint'(adj) : sv + longint'(adj));
        o.finished = 1'b0;
        return o;
    endfunction

    function automatic ei_pkg::ei_req_t random_tween();
        ei_pkg::ei_req_t r;
        int unsigned kind;
        int unsigned dur;
        r.ease_mode = ei_pkg::ease_mode_t'($urandom_range(3));
        r.start_value = $urandom();
        r.dest_value = $urandom();
        if ($urandom_range(3) == 0)
            r.dest_value = r.start_value + $signed($urandom_range(2000)) - 1000;
        r.start_time = $urandom();
        kind = $urandom_range(9);
        dur = (kind < 5) ? $urandom_range(1, 1000) : $urandom();
        r.end_time = r.start_time + dur;
        if (kind == 9)
            r.now_time = $urandom();
        else if (kind == 8)
            r.now_time = r.start_time - $urandom_range(1, 100);
        else if (kind == 7)
            r.now_time = r.end_time + $urandom_range(0, 3);
        else
            r.now_time = r.start_time + $urandom_range(0, dur - 1);
        return r;
    endfunction

    function automatic ei_pkg::ei_req_t build_tween(ei_pkg::ease_mode_t m, logic [31:0] sv,
                                                    logic [31:0] dv, logic [31:0] ts,
                                                    logic [31:0] te, logic [31:0] tn);
        ei_pkg::ei_req_t r;
        r.ease_mode = m;
        r.start_value = sv;
        r.dest_value = dv;
        r.start_time = ts;
        r.end_time = te;
        r.now_time = tn;
        return r;
    endfunction

    initial
    begin
        for (int m = 0; m < 4; m++)
        begin
            pending_reqs.push_back(build_tween(ei_pkg::ease_mode_t'(m), 32'h8000_0000,
                                               32'h7fff_ffff, 0, 1000, 500));
            pending_reqs.push_back(build_tween(ei_pkg::ease_mode_t'(m), 32'h7fff_ffff,
                                               32'h8000_0000, 100, 200, 199));
            pending_reqs.push_back(build_tween(ei_pkg::ease_mode_t'(m), 32'h0001_0000,
                                               32'h0002_0000, 32'hffff_fff0, 32'hffff_ffff,
                                               32'hffff_fff0));
        end
        pending_reqs.push_back(build_tween(ei_pkg::EASE_LINEAR, 5, 9, 10, 10, 3));
        pending_reqs.push_back(build_tween(ei_pkg::EASE_QUINT_IN, 5, 9, 10, 20, 20));
        pending_reqs.push_back(build_tween(ei_pkg::EASE_QUINT_OUT, 5, 9, 10, 20,
                                           32'hffff_ffff));
        pending_reqs.push_back(build_tween(ei_pkg::EASE_QUAD_IN_OUT, 5, 9, 10, 20, 2));
        pending_reqs.push_back(build_tween(ei_pkg::EASE_QUAD_IN_OUT, -7, 1000, 0, 2, 1));
        pending_reqs.push_back(build_tween(ei_pkg::EASE_LINEAR, 0, 0, 0, 32'hffff_ffff,
                                           32'hffff_fffe));
        pending_reqs.push_back(build_tween(ei_pkg::EASE_LINEAR, 32'hffff_ffff, 0, 0,
                                           32'hffff_ffff, 0));
        for (int i = 0; i < 1950; i++)
            pending_reqs.push_back(random_tween());
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                expected_rsps.push_back(interpolate(req));
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    req_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    int cycle_count = 0;
    int hold_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count == 300 || cycle_count == 3000)
                hold_count <= 120;
            else if (hold_count > 0)
                hold_count <= hold_count - 1;
            if (hold_count > 1)
                rsp_stall <= 1'b1;
            else if ((cycle_count / 500) % 2 == 0)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected response, actual %h/%b", $time,
                         rsp.current_value, rsp.finished);
                error_count <= error_count + 1;
            end
            else if (rsp !== expected_rsps[0])
            begin
                $display("%0t: mismatch, expected %h/%b, actual %h/%b", $time,
                         expected_rsps[0].current_value, expected_rsps[0].finished,
                         rsp.current_value, rsp.finished);
                error_count <= error_count + 1;
                void'(expected_rsps.pop_front());
            end
            else
                void'(expected_rsps.pop_front());
        end
    end

    initial
    begin
        wait (stim_done && expected_rsps.size() == 0);
        repeat (LATENCY * 2) @(posedge clk);
        if (error_count == 0 && expected_rsps.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
